@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define TBCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked through reset as well
`define TBCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tbcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tbcs_pkg;

    localparam int CW  = 32;
    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int NCW = PW + 1;
    localparam int DW  = 104;
    localparam int NW  = 136;
    localparam int SW  = 150;
    localparam int KW  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

    localparam logic [KW-1:0] SHADE_FLOOR = 8'd25;
    localparam logic [KW-1:0] SHADE_NONE  = 8'd0;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t v0_x;
        coord_t v0_y;
        coord_t v0_z;
        coord_t v1_x;
        coord_t v1_y;
        coord_t v1_z;
        coord_t v2_x;
        coord_t v2_y;
        coord_t v2_z;
    } tri_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cam_t;

    typedef struct packed {
        logic           visible;
        logic [KW-1:0]  shade;
    } result_t;

    typedef struct packed {
        logic signed [NCW-1:0] nx;
        logic signed [NCW-1:0] ny;
        logic signed [NCW-1:0] nz;
        logic signed [EW-1:0]  rx;
        logic signed [EW-1:0]  ry;
        logic signed [EW-1:0]  rz;
    } cross_t;

    typedef struct packed {
        logic           vis;
        logic           nz_neg;
        logic [NW-1:0]  n2;
        logic [NW-1:0]  z2;
    } norm_t;

    typedef struct packed {
        logic           vis;
        logic           floor;
        logic [SW-1:0]  lim;
        logic [SW-1:0]  n2;
        logic [SW-1:0]  k2n;
        logic [SW-1:0]  kn;
        logic [KW-1:0]  k;
    } step_t;

endpackage

`default_nettype wire

@@ rtl/tbcs_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tbcs_tri_if;
    import tbcs_pkg::*;
    logic valid;
    logic ready;
    tri_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbcs_res_if;
    import tbcs_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbcs_cfg_if;
    import tbcs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CW-1:0]        data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tbcs_cross.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tbcs_cross (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tbcs_pkg::tri_t  in_data,
    input  wire tbcs_pkg::cam_t  cam,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tbcs_pkg::cross_t     out_data
);
    import tbcs_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic signed [EW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [EW-1:0] rx1_reg, ry1_reg, rz1_reg, rx2_reg, ry2_reg, rz2_reg;
    logic signed [PW-1:0] p_aybz_reg, p_azby_reg, p_azbx_reg;
    logic signed [PW-1:0] p_axbz_reg, p_axby_reg, p_aybx_reg;
    cross_t               out_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ax_reg  <= {in_data.v1_x[CW-1], in_data.v1_x} - {in_data.v0_x[CW-1], in_data.v0_x};
            ay_reg  <= {in_data.v1_y[CW-1], in_data.v1_y} - {in_data.v0_y[CW-1], in_data.v0_y};
            az_reg  <= {in_data.v1_z[CW-1], in_data.v1_z} - {in_data.v0_z[CW-1], in_data.v0_z};
            bx_reg  <= {in_data.v2_x[CW-1], in_data.v2_x} - {in_data.v0_x[CW-1], in_data.v0_x};
            by_reg  <= {in_data.v2_y[CW-1], in_data.v2_y} - {in_data.v0_y[CW-1], in_data.v0_y};
            bz_reg  <= {in_data.v2_z[CW-1], in_data.v2_z} - {in_data.v0_z[CW-1], in_data.v0_z};
            rx1_reg <= {in_data.v0_x[CW-1], in_data.v0_x} - {cam.x[CW-1], cam.x};
            ry1_reg <= {in_data.v0_y[CW-1], in_data.v0_y} - {cam.y[CW-1], cam.y};
            rz1_reg <= {in_data.v0_z[CW-1], in_data.v0_z} - {cam.z[CW-1], cam.z};
        end
        if (rdy2)
        begin
            p_aybz_reg <= ay_reg * bz_reg;
            p_azby_reg <= az_reg * by_reg;
            p_azbx_reg <= az_reg * bx_reg;
            p_axbz_reg <= ax_reg * bz_reg;
            p_axby_reg <= ax_reg * by_reg;
            p_aybx_reg <= ay_reg * bx_reg;
            rx2_reg    <= rx1_reg;
            ry2_reg    <= ry1_reg;
            rz2_reg    <= rz1_reg;
        end
        if (rdy3)
        begin
            out_reg.nx <= {p_aybz_reg[PW-1], p_aybz_reg} - {p_azby_reg[PW-1], p_azby_reg};
            out_reg.ny <= {p_azbx_reg[PW-1], p_azbx_reg} - {p_axbz_reg[PW-1], p_axbz_reg};
            out_reg.nz <= {p_axby_reg[PW-1], p_axby_reg} - {p_aybx_reg[PW-1], p_aybx_reg};
            out_reg.rx <= rx2_reg;
            out_reg.ry <= ry2_reg;
            out_reg.rz <= rz2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ rtl/tbcs_norm.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tbcs_norm (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tbcs_pkg::cross_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tbcs_pkg::norm_t        out_data
);
    import tbcs_pkg::*;

    localparam int LW = 34;
    localparam int HW = NCW - LW;
    localparam int PLW = LW + 1 + EW;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // per component: high/low split of the normal, partial products
    logic signed [HW+EW-1:0] prh_reg [0:2];
    logic signed [PLW-1:0]   prl_reg [0:2];
    logic signed [2*HW-1:0]  sqh_reg [0:2];
    logic signed [LW+1+HW-1:0] sqm_reg [0:2];
    logic [2*LW-1:0]         sql_reg [0:2];
    logic                    nzn1_reg, nzn2_reg;

    logic signed [DW-1:0]    dp_reg [0:2];
    logic signed [NW-1:0]    sp_reg [0:2];

    norm_t                   out_reg;

    logic signed [NCW-1:0]   n_comp [0:2];
    logic signed [EW-1:0]    r_comp [0:2];

    assign n_comp[0] = in_data.nx;
    assign n_comp[1] = in_data.ny;
    assign n_comp[2] = in_data.nz;
    assign r_comp[0] = in_data.rx;
    assign r_comp[1] = in_data.ry;
    assign r_comp[2] = in_data.rz;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_comp
        logic signed [HW-1:0] nh;
        logic signed [LW:0]   nl;
        assign nh = $signed(n_comp[c][NCW-1:LW]);
        assign nl = $signed({1'b0, n_comp[c][LW-1:0]});

        always_ff @(posedge clk)
        begin
            if (rdy1)
            begin
                prh_reg[c] <= nh * r_comp[c];
                prl_reg[c] <= nl * r_comp[c];
                sqh_reg[c] <= nh * nh;
                sqm_reg[c] <= nl * nh;
                sql_reg[c] <= n_comp[c][LW-1:0] * n_comp[c][LW-1:0];
            end
            if (rdy2)
            begin
                dp_reg[c] <= (DW'(prh_reg[c]) <<< LW) + DW'(prl_reg[c]);
                sp_reg[c] <= (NW'(sqh_reg[c]) <<< (2 * LW)) + (NW'(sqm_reg[c]) <<< (LW + 1))
                           + $signed(NW'(sql_reg[c]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1) nzn1_reg <= in_data.nz[NCW-1];
        if (rdy2) nzn2_reg <= nzn1_reg;
        if (rdy3)
        begin
            logic signed [DW-1:0] d_sum;
            d_sum          = dp_reg[0] + dp_reg[1] + dp_reg[2];
            out_reg.vis    <= d_sum[DW-1];
            out_reg.nz_neg <= nzn2_reg;
            out_reg.n2     <= sp_reg[0] + sp_reg[1] + sp_reg[2];
            out_reg.z2     <= sp_reg[2];
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ rtl/tbcs_shade.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tbcs_shade (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tbcs_pkg::norm_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tbcs_pkg::step_t        out_data
);
    import tbcs_pkg::*;

    localparam int NS = KW + 1;

    logic  vld_reg [0:NS-1];
    step_t stg_reg [0:NS-1];
    logic  rdy     [0:NS];
    step_t init_next;

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < NS; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    // setup: 65025*z2 limit and the floor test, 100*z2 against n2
    always_comb
    begin
        logic [SW-1:0] z;
        logic [SW-1:0] hund;
        z                 = SW'(in_data.z2);
        hund              = (z << 6) + (z << 5) + (z << 2);
        init_next.vis     = in_data.vis;
        init_next.n2      = SW'(in_data.n2);
        init_next.lim     = (z << 16) - (z << 9) + z;
        init_next.floor   = !in_data.nz_neg || (hund <= SW'(in_data.n2));
        init_next.k2n     = '0;
        init_next.kn      = '0;
        init_next.k       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (rdy[0])
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) stg_reg[0] <= init_next;
    end

    // one result bit per stage, MSB first; k^2*n2 and k*n2 kept incrementally
    for (genvar i = 1; i < NS; i++)
    begin : g_step
        localparam int S = KW - i;
        step_t step_next;

        always_comb
        begin
            logic [SW-1:0] trial;
            step_t         p;
            p         = stg_reg[i-1];
            trial     = p.k2n + (p.kn << (S + 1)) + (p.n2 << (2 * S));
            step_next = p;
            if (trial <= p.lim)
            begin
                step_next.k2n = trial;
                step_next.kn  = p.kn + (p.n2 << S);
                step_next.k   = p.k | (KW'(1) << S);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (rdy[i])
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i]) stg_reg[i] <= step_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_data  = stg_reg[NS-1];

endmodule

`default_nettype wire

@@ rtl/triangle_backface_cull_shade_top.sv @@
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+----------------------------------------
//  triangle  | in  | valid/ready   | v0_x..v2_z, nine signed Q16.16 words
//  result    | out | valid/ready   | visible (1 bit), shade (8 bits)
//  cfg       | in  | valid/ready   | index (0 cam x, 1 cam y, 2 cam z), data
//
//  One triangle accepted per cycle unless result stalls; stages: cross product 3,
//  square/dot 3, shade search 9 (a setup stage, then one result bit per stage), output 1.
//  The rate is set by the fully pipelined datapath: every stage holds one item.
//  Reset clears valid bits and camera registers; cfg is always ready.
//  A stall on result holds each full stage; empty stages still fill.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_backface_cull_shade_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbcs_tri_if.sink    triangle,
    tbcs_res_if.source  result,
    tbcs_cfg_if.sink    cfg
);
    import tbcs_pkg::*;

    cam_t    cam_reg;
    logic    ov_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_rdy;

    logic    c_valid, c_ready;
    cross_t  c_data;
    logic    n_valid, n_ready;
    norm_t   n_data;
    logic    s_valid;
    step_t   s_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cam_reg <= '0;
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CAMERA_X: cam_reg.x <= cfg.data;
                CFG_CAMERA_Y: cam_reg.y <= cfg.data;
                CFG_CAMERA_Z: cam_reg.z <= cfg.data;
                default:      cam_reg   <= cam_reg;
            endcase
        end
    end

    tbcs_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (triangle.valid),
        .in_ready  (triangle.ready),
        .in_data   (triangle.data),
        .cam       (cam_reg),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    tbcs_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (n_valid),
        .out_ready (n_ready),
        .out_data  (n_data)
    );

    tbcs_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid),
        .in_ready  (n_ready),
        .in_data   (n_data),
        .out_valid (s_valid),
        .out_ready (out_rdy),
        .out_data  (s_data)
    );

    assign out_rdy = !ov_reg || result.ready;

    always_comb
    begin
        res_next.visible = s_data.vis;
        if (!s_data.vis)
            res_next.shade = SHADE_NONE;
        else if (s_data.floor)
            res_next.shade = SHADE_FLOOR;
        else
            res_next.shade = s_data.k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_rdy)
            ov_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy) res_reg <= res_next;
    end

    assign result.valid = ov_reg;
    assign result.data  = res_reg;

    `TBCS_ASSERT(a_hidden_dark, clk, rst_n, result.valid && !result.data.visible |-> result.data.shade == SHADE_NONE, "hidden face with nonzero shade")
    `TBCS_ASSERT(a_visible_floor, clk, rst_n, result.valid && result.data.visible |-> result.data.shade >= SHADE_FLOOR, "visible face below floor")
    `TBCS_ASSERT(a_cam_x_write, clk, rst_n, cfg.valid && cfg.index == CFG_CAMERA_X |=> cam_reg.x == $past(cfg.data), "camera x not written")
    `TBCS_ASSERT_ALWAYS(a_ready_when_drained, clk, !ov_reg |-> triangle.ready, "input stalled with empty output")

endmodule

`default_nettype wire
